[rtl/bhcc_pkg.sv]
// Shared constants and types for the byte histogram compressibility check.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bhcc_pkg;

    // Page and symbol geometry.
    localparam int PAGE_BYTES   = 4096;
    localparam int SYMBOL_COUNT = 256;

    // Field widths.
    localparam int SYM_W      = 8;
    localparam int CNT_W      = 13;
    localparam int LEAST_W    = 9;
    localparam int DIST_W     = 9;
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Counter limit, page-state start values and register reset values.
    localparam logic [CNT_W-1:0]   PAGE_LIMIT        = CNT_W'(PAGE_BYTES);
    localparam logic [LEAST_W-1:0] INITIAL_LEAST     = LEAST_W'(256);
    localparam logic [THR_W-1:0]   DEFAULT_THRESHOLD = THR_W'(150);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPREAD_THRESHOLD     = 1'b0,
        CFG_COMPRESSION_DISABLED = 1'b1
    } t_cfg_idx;

endpackage

[rtl/bhcc_in_if.sv]
// Input channel: one page byte per request with a last-byte mark.
// Depends on bhcc_pkg for the field widths.
`timescale 1ns / 1ps

interface bhcc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bhcc_pkg::SYM_W-1:0]  byte_value;
    logic                        last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

[rtl/bhcc_out_if.sv]
// Result channel: verdict and status for one finished page.
// Depends on bhcc_pkg for the field widths.
`timescale 1ns / 1ps

interface bhcc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         compressible;
    logic [bhcc_pkg::CNT_W-1:0]   max_count;
    logic [bhcc_pkg::DIST_W-1:0]  distinct_symbols;

    modport source (output valid, output compressible, output max_count,
                    output distinct_symbols, input ready);
    modport sink   (input valid, input compressible, input max_count,
                    input distinct_symbols, output ready);
endinterface

[rtl/byte_histogram_compressibility_check.sv]
// Top level of the byte histogram compressibility check.
// Depends on bhcc_pkg, bhcc_in_if and bhcc_out_if.
// --------------------------------------------------------------------------
//  Channel    Dir  Carries                                      Requests
//  i_in_ch    in   byte_value, last_byte                        one per byte
//  o_out_ch   out  compressible, max_count, distinct_symbols    one per page
//  i_cfg_*    in   register index and write data                one per write
//
//  One byte is accepted every cycle while input ready is high; its counter
//  is read at the accepting edge and then, in the update stage, incremented
//  and written back, with a bypass for a repeat of the previous byte value.
//  The page result is registered when its last byte leaves the update stage.
//  Reset is synchronous and needs no clearing pass: a valid bit per counter
//  is cleared at once, and again after every last byte.
//  Input ready drops only while a last byte waits behind an untaken result.
// --------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_histogram_compressibility_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bhcc_in_if.sink                             i_in_ch,
    bhcc_out_if.source                          o_out_ch,
    input  logic                                i_cfg_we,
    input  logic [bhcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bhcc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SYM_W   = bhcc_pkg::SYM_W;
    localparam int CNT_W   = bhcc_pkg::CNT_W;
    localparam int LEAST_W = bhcc_pkg::LEAST_W;
    localparam int DIST_W  = bhcc_pkg::DIST_W;
    localparam int THR_W   = bhcc_pkg::THR_W;

    // Counter memory and per-entry valid bits.
    logic [CNT_W-1:0]                   r_mem [bhcc_pkg::SYMBOL_COUNT];
    logic [bhcc_pkg::SYMBOL_COUNT-1:0]  r_valid;
    logic [CNT_W-1:0]                   r_rd_data;

    // Update stage.
    logic              r_s1_valid;
    logic [SYM_W-1:0]  r_s1_byte;
    logic              r_s1_last;
    logic              r_fwd_hit;
    logic [CNT_W-1:0]  r_fwd_val;

    // Page state.
    logic [CNT_W-1:0]   r_peak;
    logic [LEAST_W-1:0] r_least;
    logic [DIST_W-1:0]  r_distinct;

    // Configuration registers.
    logic [THR_W-1:0]  r_thr;
    logic              r_dis;

    // Result register.
    logic               r_out_valid;
    logic               r_out_comp;
    logic [CNT_W-1:0]   r_out_max;
    logic [DIST_W-1:0]  r_out_dist;

    // Combinational terms.
    logic               stall;
    logic               accept;
    logic               s1_adv;
    logic               s1_done_last;
    logic [CNT_W-1:0]   c_old;
    logic [CNT_W-1:0]   c_new;
    logic [CNT_W-1:0]   n_peak;
    logic [LEAST_W-1:0] n_least;
    logic [DIST_W-1:0]  n_distinct;
    logic [CNT_W-1:0]   least_ext;
    logic [CNT_W-1:0]   spread;
    logic               verdict;

    // Handshake: hold only when a last byte cannot hand over its result.
    assign stall          = r_s1_valid && r_s1_last && r_out_valid && !o_out_ch.ready;
    assign i_in_ch.ready  = !stall;
    assign accept         = i_in_ch.valid && !stall;
    assign s1_adv         = r_s1_valid && !stall;
    assign s1_done_last   = s1_adv && r_s1_last;

    // Counter update with bypass from the previous byte and valid-bit masking.
    always_comb begin
        if (r_fwd_hit) begin
            c_old = r_fwd_val;
        end else if (r_valid[r_s1_byte]) begin
            c_old = r_rd_data;
        end else begin
            c_old = '0;
        end
        c_new      = (c_old < bhcc_pkg::PAGE_LIMIT) ? c_old + CNT_W'(1) : c_old;
        n_peak     = (c_new > r_peak) ? c_new : r_peak;
        least_ext  = CNT_W'(r_least);
        n_least    = (c_new < least_ext) ? LEAST_W'(c_new) : r_least;
        n_distinct = (c_old == '0) ? r_distinct + DIST_W'(1) : r_distinct;
    end

    // Verdict from the page state including the last byte.
    always_comb begin
        if (n_peak >= CNT_W'(n_least)) begin
            spread = n_peak - CNT_W'(n_least);
        end else begin
            spread = '0;
        end
        verdict = !r_dis && (spread >= r_thr);
    end

    // Counter memory: write-back from the update stage, registered read on accept.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_byte] <= c_new;
        end
        if (accept) begin
            r_rd_data <= r_mem[i_in_ch.byte_value];
        end
    end

    // Valid bits: set on write-back, all cleared at reset and after a page.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_valid <= '0;
            end else begin
                r_valid[r_s1_byte] <= 1'b1;
            end
        end
    end

    // Update stage control and bypass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_fwd_hit  <= r_s1_valid && !r_s1_last && (i_in_ch.byte_value == r_s1_byte);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end
    end

    // Update stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte <= i_in_ch.byte_value;
            r_s1_last <= i_in_ch.last_byte;
            r_fwd_val <= c_new;
        end
    end

    // Page state: advance per byte, return to start values after a page.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= '0;
            r_least    <= bhcc_pkg::INITIAL_LEAST;
            r_distinct <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_peak     <= '0;
                r_least    <= bhcc_pkg::INITIAL_LEAST;
                r_distinct <= '0;
            end else begin
                r_peak     <= n_peak;
                r_least    <= n_least;
                r_distinct <= n_distinct;
            end
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= bhcc_pkg::DEFAULT_THRESHOLD;
            r_dis <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (bhcc_pkg::t_cfg_idx'(i_cfg_idx))
                bhcc_pkg::CFG_SPREAD_THRESHOLD: begin
                    r_thr <= THR_W'(i_cfg_data);
                end
                bhcc_pkg::CFG_COMPRESSION_DISABLED: begin
                    r_dis <= i_cfg_data[0];
                end
                default: begin
                    r_thr <= r_thr;
                end
            endcase
        end
    end

    // Result register: loaded on a last byte, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done_last) begin
            r_out_comp <= verdict;
            r_out_max  <= n_peak;
            r_out_dist <= n_distinct;
        end
    end

    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.compressible     = r_out_comp;
    assign o_out_ch.max_count        = r_out_max;
    assign o_out_ch.distinct_symbols = r_out_dist;

    // The distinct count can never pass the number of byte values.
    a_distinct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_distinct <= DIST_W'(bhcc_pkg::SYMBOL_COUNT))
        else $error("distinct count exceeds symbol count");

    // A finished page leaves the page state at its start values.
    a_page_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done_last |=> (r_peak == '0) && (r_distinct == '0) &&
                         (r_least == bhcc_pkg::INITIAL_LEAST) && (r_valid == '0))
        else $error("page state not cleared after last byte");

    // The bypass only ever refers to an occupied update stage.
    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("bypass set with empty update stage");

    // A result only appears after a last byte has left the update stage.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_done_last))
        else $error("result raised without a last byte");

    // The least count never rises above its start value.
    a_least_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_least <= bhcc_pkg::INITIAL_LEAST)
        else $error("least count above start value");

endmodule

[test/tb_byte_histogram_compressibility_check.sv]
// Self-checking testbench for the byte histogram compressibility check.
// Streams pages of bytes, predicts each page verdict and checks every result.
// Depends on bhcc_pkg, bhcc_in_if, bhcc_out_if and the top level.
`timescale 1ns / 1ps

module tb_byte_histogram_compressibility_check;

    localparam int SYM_W        = bhcc_pkg::SYM_W;
    localparam int CNT_W        = bhcc_pkg::CNT_W;
    localparam int LEAST_W      = bhcc_pkg::LEAST_W;
    localparam int DIST_W       = bhcc_pkg::DIST_W;
    localparam int THR_W        = bhcc_pkg::THR_W;
    localparam int CFG_DATA_W   = bhcc_pkg::CFG_DATA_W;
    localparam int SYMBOL_COUNT = bhcc_pkg::SYMBOL_COUNT;

    localparam int BYTE_TARGET   = 1650;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX    = 10;

    typedef bhcc_pkg::t_cfg_idx t_cfg_idx;

    typedef struct packed {
        logic [SYM_W-1:0] value;
        logic             last;
    } t_page_byte;

    typedef struct packed {
        logic              compressible;
        logic [CNT_W-1:0]  max_count;
        logic [DIST_W-1:0] distinct_symbols;
    } t_page_verdict;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bhcc_in_if  in_ch ();
    bhcc_out_if out_ch ();

    byte_histogram_compressibility_check DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Bytes waiting to be sent and page verdicts waiting to arrive.
    t_page_byte    bytes_pending[$];
    t_page_verdict verdicts_due[$];

    // Predicted page state and register copies.
    logic [CNT_W-1:0]   sym_hist [SYMBOL_COUNT];
    logic [CNT_W-1:0]   hist_peak;
    logic [LEAST_W-1:0] hist_least;
    logic [DIST_W-1:0]  hist_distinct;
    logic [THR_W-1:0]   spread_thr;
    logic               verdict_off;

    int  bytes_queued;
    int  bytes_taken;
    int  random_bytes;
    int  fail_cnt;
    int  quiet_cycles;
    int  send_gap;
    int  recv_stall;
    bit  idle_on;
    bit  byte_taken;

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Start-of-run values for every block input and the predictor.
    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.last_byte  = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = bhcc_pkg::CFG_SPREAD_THRESHOLD;
        cfg_data         = '0;
        foreach (sym_hist[i]) sym_hist[i] = '0;
        hist_peak     = '0;
        hist_least    = bhcc_pkg::INITIAL_LEAST;
        hist_distinct = '0;
        spread_thr    = bhcc_pkg::DEFAULT_THRESHOLD;
        verdict_off   = 1'b0;
        bytes_queued  = 0;
        bytes_taken   = 0;
        random_bytes  = 0;
        fail_cnt      = 0;
        quiet_cycles  = 0;
        send_gap      = 0;
        recv_stall    = 0;
        idle_on       = 1'b1;
        byte_taken    = 1'b0;
    end

    // Histogram predictor: counts one byte and, on the last byte of a page,
    // queues the verdict and clears the page state.
    task automatic account_byte(input logic [SYM_W-1:0] value, input logic last);
        logic [CNT_W-1:0] cnt;
        int               spread;
        t_page_verdict    verdict;
        cnt = sym_hist[value];
        if (cnt < bhcc_pkg::PAGE_LIMIT) begin
            cnt = cnt + CNT_W'(1);
            sym_hist[value] = cnt;
            if (cnt == CNT_W'(1)) hist_distinct = hist_distinct + DIST_W'(1);
        end
        if (cnt < hist_least) hist_least = LEAST_W'(cnt);
        if (cnt > hist_peak) hist_peak = cnt;
        if (last) begin
            spread = (hist_peak >= hist_least) ? int'(hist_peak) - int'(hist_least) : 0;
            verdict.compressible     = !verdict_off && (spread >= int'(spread_thr));
            verdict.max_count        = hist_peak;
            verdict.distinct_symbols = hist_distinct;
            verdicts_due.push_back(verdict);
            foreach (sym_hist[i]) sym_hist[i] = '0;
            hist_peak     = '0;
            hist_least    = bhcc_pkg::INITIAL_LEAST;
            hist_distinct = '0;
        end
    endtask

    // Byte driver: presents queued bytes, with random bursts of idle cycles.
    always @(negedge i_clk) begin : drive_bytes
        t_page_byte nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !byte_taken) begin
            // The current request has not been taken yet, so it is held.
        end else if (send_gap > 0) begin
            send_gap    <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (bytes_pending.size() != 0) begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                send_gap    <= $urandom_range(0, 9);
                in_ch.valid <= 1'b0;
            end else begin
                nxt = bytes_pending.pop_front();
                in_ch.byte_value <= nxt.value;
                in_ch.last_byte  <= nxt.last;
                in_ch.valid      <= 1'b1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Result receiver: ready is dropped in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall   <= recv_stall - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_stall   <= $urandom_range(0, 9);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted byte, checks each accepted result,
    // and ends the run if nothing moves for too long.
    always @(posedge i_clk) begin : watch_channels
        t_page_verdict want;
        t_page_verdict got;
        byte_taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                account_byte(in_ch.byte_value, in_ch.last_byte);
                bytes_taken = bytes_taken + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.compressible     = out_ch.compressible;
                got.max_count        = out_ch.max_count;
                got.distinct_symbols = out_ch.distinct_symbols;
                if (verdicts_due.size() == 0) begin
                    if (fail_cnt < REPORT_MAX)
                        $display("%t: unexpected page result %p", $realtime, got);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got !== want) begin
                        if (fail_cnt < REPORT_MAX)
                            $display("%t: page result mismatch, expected %p, got %p",
                                     $realtime, want, got);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%t: no request accepted for %0d cycles", $realtime, STALL_LIMIT);
                $display("** byte_histogram_compressibility_check: FAILED **");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [SYM_W-1:0] value, input logic last);
        t_page_byte item;
        item.value = value;
        item.last  = last;
        bytes_pending.push_back(item);
        bytes_queued = bytes_queued + 1;
    endtask

    // Waits until every byte is taken and every verdict has arrived.
    task automatic settle();
        while (bytes_taken != bytes_queued || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; only called while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            bhcc_pkg::CFG_SPREAD_THRESHOLD:     spread_thr  = data;
            bhcc_pkg::CFG_COMPRESSION_DISABLED: verdict_off = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // One random page: mostly short, of random, narrow-range or skewed bytes;
    // sometimes long and skewed near the default spread, or every byte value.
    task automatic queue_random_page();
        int               kind;
        int               len;
        int               style;
        int               width;
        int               j;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] value;
        logic [SYM_W-1:0] perm [SYMBOL_COUNT];
        kind  = $urandom_range(0, 29);
        base  = SYM_W'($urandom);
        width = $urandom_range(0, 3);
        if (kind == 0) begin
            foreach (perm[i]) perm[i] = SYM_W'(i);
            for (int i = SYMBOL_COUNT - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                value   = perm[i];
                perm[i] = perm[j];
                perm[j] = value;
            end
            len = $urandom_range(0, 3);
            foreach (perm[i]) queue_byte(perm[i], (len == 0) && (i == SYMBOL_COUNT - 1));
            for (int i = 0; i < len; i++) queue_byte(SYM_W'($urandom), i == len - 1);
            random_bytes = random_bytes + SYMBOL_COUNT + len;
        end else begin
            if (kind == 1) begin
                len   = $urandom_range(140, 260);
                style = 2;
            end else begin
                len   = $urandom_range(1, 24);
                style = $urandom_range(0, 2);
            end
            for (int i = 0; i < len; i++) begin
                case (style)
                    0:       value = SYM_W'($urandom);
                    1:       value = base + SYM_W'($urandom_range(0, width));
                    default: value = ($urandom_range(0, 7) != 0) ? base : SYM_W'($urandom);
                endcase
                queue_byte(value, i == len - 1);
            end
            random_bytes = random_bytes + len;
        end
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        int                    pick;
        logic [CFG_DATA_W-1:0] thr;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pages, first with the reset register values.
        queue_byte(8'h00, 1'b1);
        settle();
        write_reg(bhcc_pkg::CFG_SPREAD_THRESHOLD, '0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'hAA, 1'b1);
        settle();
        write_reg(bhcc_pkg::CFG_SPREAD_THRESHOLD, CFG_DATA_W'(2));
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h07, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b1);
        settle();
        // Disabled: the verdict is forced low, the status fields still count.
        write_reg(bhcc_pkg::CFG_SPREAD_THRESHOLD, '0);
        write_reg(bhcc_pkg::CFG_COMPRESSION_DISABLED, {12'hFFF, 1'b1});
        queue_byte(8'h09, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b1);
        settle();
        write_reg(bhcc_pkg::CFG_COMPRESSION_DISABLED, {12'hABC, 1'b0});
        write_reg(bhcc_pkg::CFG_SPREAD_THRESHOLD, {CFG_DATA_W{1'b1}});
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'h5A, 1'b1);
        settle();

        // Random phases, each under its own register settings.
        while (random_bytes < BYTE_TARGET) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       thr = '0;
                1:       thr = CFG_DATA_W'(1);
                2:       thr = bhcc_pkg::DEFAULT_THRESHOLD;
                3:       thr = CFG_DATA_W'($urandom_range(2, 40));
                4:       thr = CFG_DATA_W'($urandom_range(100, 250));
                5:       thr = CFG_DATA_W'(bhcc_pkg::PAGE_BYTES);
                6:       thr = {CFG_DATA_W{1'b1}};
                default: thr = CFG_DATA_W'($urandom);
            endcase
            write_reg(bhcc_pkg::CFG_SPREAD_THRESHOLD, thr);
            write_reg(bhcc_pkg::CFG_COMPRESSION_DISABLED,
                      {12'($urandom), 1'($urandom_range(0, 4) == 0)});
            if (random_bytes >= BYTE_TARGET - 250) idle_on = 1'b0;
            repeat ($urandom_range(4, 10)) queue_random_page();
            settle();
        end

        // Drain, then give a late or spurious result time to show.
        settle();
        repeat (10) @(negedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0d page results never arrived", verdicts_due.size());
            fail_cnt = fail_cnt + 1;
        end
        if (fail_cnt == 0)
            $display("** byte_histogram_compressibility_check: PASSED **");
        else
            $display("** byte_histogram_compressibility_check: FAILED **");
        $finish;
    end

endmodule
